[src/bmhq_pkg.sv]
// Shared types, constants and helpers for the binary min-heap queue.
package bmhq_pkg;

   localparam int CAPACITY    = 1024;
   localparam int ADDR_W      = $clog2(CAPACITY);
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int IDX_W       = ADDR_W + 2;
   localparam int KEY_W       = 31;
   localparam int SYM_W       = 8;
   localparam int TAG_W       = 11;
   localparam int OPCODE_W    = 2;
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 11;

   typedef enum logic [OPCODE_W-1:0] {
      OP_INSERT = 2'd0,
      OP_POP    = 2'd1,
      OP_CLEAR  = 2'd2
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [SYM_W-1:0] symbol;
      logic [TAG_W-1:0] tag;
   } entry_type;

   typedef struct packed {
      status_type             status;
      logic [KEY_W-1:0]       key;
      logic [SYM_W-1:0]       symbol;
      logic [TAG_W-1:0]       tag;
      logic [COUNT_OUT_W-1:0] count;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS_CMP,
      ST_INS_PUT,
      ST_POP_ROOT,
      ST_POP_LAST,
      ST_POP_L,
      ST_POP_R,
      ST_POP_PUT,
      ST_RESP
   } state_type;

   function automatic logic [ADDR_W-1:0] parent_of(input logic [ADDR_W-1:0] i);
      logic [ADDR_W-1:0] d;
      d = i - 1'b1;
      return d >> 1;
   endfunction

endpackage

[src/bmhq_req_if.sv]
// Request channel: one heap operation per item.
interface bmhq_req_if import bmhq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [KEY_W-1:0]    key_in;
   logic [SYM_W-1:0]    symbol_in;
   logic [TAG_W-1:0]    tag_in;

   modport source (output valid, opcode, key_in, symbol_in, tag_in, input ready);
   modport sink   (input valid, opcode, key_in, symbol_in, tag_in, output ready);
endinterface

[src/bmhq_rsp_if.sv]
// Response channel: one result item per request.
interface bmhq_rsp_if import bmhq_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [STATUS_W-1:0]    status;
   logic [KEY_W-1:0]       key_out;
   logic [SYM_W-1:0]       symbol_out;
   logic [TAG_W-1:0]       tag_out;
   logic [COUNT_OUT_W-1:0] count_out;

   modport source (output valid, status, key_out, symbol_out, tag_out, count_out,
                   input ready);
   modport sink   (input valid, status, key_out, symbol_out, tag_out, count_out,
                   output ready);
endinterface

[src/binary_min_heap_queue_top.sv]
// Binary min-heap priority queue held in a single-port-read, single-port-write RAM.
// Items are processed one at a time. An insert moves each larger parent down one
// level, then writes the new entry. A pop reads the root, then the last entry, then
// sifts down, reading the left and then any right child through the one RAM read
// port, and a final write places the moved entry when it ends at a leaf. Clear,
// error cases and the unused opcode go straight to the response. A finished result
// sits in an output register, so the next item is taken while it waits. The heap
// RAM needs no clearing after reset; only entries below the fill count are ever read.
module binary_min_heap_queue_top import bmhq_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   bmhq_req_if.sink   req_ch,
   bmhq_rsp_if.source rsp_ch
);

   entry_type heap_mem [CAPACITY];

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0]  child_ff, child_in;
   entry_type         cur_ff, cur_in;
   entry_type         left_ff, left_in;
   entry_type         rd_data_ff;
   rsp_type           res_ff, res_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   entry_type         wr_data;
   logic [ADDR_W-1:0] rd_addr;

   logic              take_right;
   entry_type         sel_entry;
   logic [IDX_W-1:0]  sel_idx;
   logic [IDX_W-1:0]  next_left;
   logic [IDX_W-1:0]  count_ext;
   logic [CNT_W-1:0]  last_idx;
   logic [ADDR_W-1:0] par_idx;
   logic              step;

   assign count_ext  = IDX_W'(count_ff);
   assign last_idx   = count_ff - 1'b1;
   assign par_idx    = parent_of(idx_ff);
   // right child wins only when strictly smaller
   assign take_right = (state_ff == ST_POP_R) && (left_ff.key > rd_data_ff.key);
   assign sel_entry  = (state_ff == ST_POP_R) ? (take_right ? rd_data_ff : left_ff)
                                              : rd_data_ff;
   assign sel_idx    = take_right ? (child_ff + 1'b1) : child_ff;
   assign next_left  = {sel_idx[IDX_W-2:0], 1'b1};

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      child_in     = child_ff;
      cur_in       = cur_ff;
      left_in      = left_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ch.ready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = cur_ff;
      rd_addr      = '0;
      req_ch.ready = 1'b0;
      step         = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               res_in   = '0;
               cur_in   = '{key: req_ch.key_in, symbol: req_ch.symbol_in,
                            tag: req_ch.tag_in};
               idx_in   = count_ff[ADDR_W-1:0];
               state_in = ST_RESP;
               unique case (req_ch.opcode)
                  OP_INSERT: begin
                     if (count_ff >= CNT_W'(CAPACITY)) begin
                        res_in.status = STATUS_FULL;
                     end else if (count_ff == '0) begin
                        state_in = ST_INS_PUT;
                     end else begin
                        rd_addr  = parent_of(count_ff[ADDR_W-1:0]);
                        state_in = ST_INS_CMP;
                     end
                  end
                  OP_POP: begin
                     if (count_ff == '0) begin
                        res_in.status = STATUS_EMPTY;
                     end else begin
                        rd_addr  = '0;
                        state_in = ST_POP_ROOT;
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_INS_CMP: begin
            wr_en = 1'b1;
            if (rd_data_ff.key > cur_ff.key) begin
               // parent moves down into the hole
               wr_data = rd_data_ff;
               idx_in  = par_idx;
               if (par_idx == '0) begin
                  state_in = ST_INS_PUT;
               end else begin
                  rd_addr = parent_of(par_idx);
               end
            end else begin
               count_in = count_ff + 1'b1;
               state_in = ST_RESP;
            end
         end
         ST_INS_PUT: begin
            wr_en    = 1'b1;
            count_in = count_ff + 1'b1;
            state_in = ST_RESP;
         end
         ST_POP_ROOT: begin
            res_in.key    = rd_data_ff.key;
            res_in.symbol = rd_data_ff.symbol;
            res_in.tag    = rd_data_ff.tag;
            count_in      = last_idx;
            rd_addr       = last_idx[ADDR_W-1:0];
            state_in      = ST_POP_LAST;
         end
         ST_POP_LAST: begin
            cur_in = rd_data_ff;
            idx_in = '0;
            if (count_ext > IDX_W'(1)) begin
               rd_addr  = ADDR_W'(1);
               child_in = IDX_W'(1);
               state_in = ST_POP_L;
            end else begin
               state_in = ST_POP_PUT;
            end
         end
         ST_POP_L: begin
            if ((child_ff + 1'b1) < count_ext) begin
               left_in  = rd_data_ff;
               rd_addr  = ADDR_W'(child_ff + 1'b1);
               state_in = ST_POP_R;
            end else begin
               step = 1'b1;
            end
         end
         ST_POP_R: begin
            step = 1'b1;
         end
         ST_POP_PUT: begin
            wr_en    = 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in      = 1'b1;
               rsp_data_in       = res_ff;
               rsp_data_in.count = COUNT_OUT_W'(count_ff);
               state_in          = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // one level of the sift-down against the chosen child
      if (step) begin
         wr_en = 1'b1;
         if (cur_ff.key <= sel_entry.key) begin
            state_in = ST_RESP;
         end else begin
            wr_data = sel_entry;
            idx_in  = sel_idx[ADDR_W-1:0];
            if (next_left < count_ext) begin
               rd_addr  = next_left[ADDR_W-1:0];
               child_in = next_left;
               state_in = ST_POP_L;
            end else begin
               state_in = ST_POP_PUT;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= heap_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      child_ff    <= child_in;
      cur_ff      <= cur_in;
      left_ff     <= left_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = rsp_data_ff.status;
   assign rsp_ch.key_out    = rsp_data_ff.key;
   assign rsp_ch.symbol_out = rsp_data_ff.symbol;
   assign rsp_ch.tag_out    = rsp_data_ff.tag;
   assign rsp_ch.count_out  = rsp_data_ff.count;

endmodule

[src/bmhq_checker.sv]
// Port-level checks for the heap queue, bound to the top level.
module bmhq_checker import bmhq_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [STATUS_W-1:0]    rsp_status,
   input logic [KEY_W-1:0]       rsp_key_out,
   input logic [COUNT_OUT_W-1:0] rsp_count_out
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn while stalled");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_EMPTY |-> rsp_key_out == '0 && rsp_count_out == '0)
      else $error("pop on empty reports data or a non-zero count");

   a_full_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FULL |-> rsp_count_out == COUNT_OUT_W'(CAPACITY))
      else $error("insert on full with count below capacity");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_count_out <= COUNT_OUT_W'(CAPACITY))
      else $error("count beyond capacity");

endmodule

bind binary_min_heap_queue_top bmhq_checker u_bmhq_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_status    (rsp_ch.status),
   .rsp_key_out   (rsp_ch.key_out),
   .rsp_count_out (rsp_ch.count_out)
);
